@@ src/hcd_pkg.sv @@
// Shared types, constants and helpers for the HTTP chunked decoder.
// No dependencies; imported by hcd_hdr_scan and http_chunked_decoder.
`default_nettype none

package hcd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned HEX_DIGIT_BITS = 4;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Progress of the digit scan on one header line.
  typedef enum logic [1:0] {
    SM_LEAD   = 2'd0,
    SM_ZERO   = 2'd1,
    SM_DIGITS = 2'd2,
    SM_END    = 2'd3
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t mode_nxt;
    logic       line_end;
    logic       digit_ovf;
  } scan_res_t;

  function automatic logic is_skip_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [HEX_DIGIT_BITS-1:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[HEX_DIGIT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/hcd_hdr_scan.sv @@
// Header line scanner: next digit-scan mode and accumulated length per byte.
// Depends on hcd_pkg.
`default_nettype none

module hcd_hdr_scan
  import hcd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [7:0]            data_byte,
  input  logic [COUNT_BITS-1:0] hdr_value,
  input  scan_mode_t            scan_mode,
  output logic [COUNT_BITS-1:0] hdr_value_nxt,
  output scan_res_t             res
);

  logic                      hex;
  logic [HEX_DIGIT_BITS-1:0] dval;
  logic                      take;
  logic                      ovf;

  assign hex  = is_hex(data_byte);
  assign dval = hex_val(data_byte);

  always_comb begin
    take         = 1'b0;
    res.mode_nxt = scan_mode;
    res.line_end = 1'b0;
    if (data_byte == CH_LF) begin
      res.line_end = 1'b1;
      res.mode_nxt = SM_LEAD;
    end else begin
      case (scan_mode)
        SM_LEAD: begin
          if (!is_skip_space(data_byte)) begin
            if (hex && (dval == '0)) begin
              res.mode_nxt = SM_ZERO;
            end else if (hex) begin
              take         = 1'b1;
              res.mode_nxt = SM_DIGITS;
            end else begin
              res.mode_nxt = SM_END;
            end
          end
        end
        SM_ZERO: begin
          if ((data_byte == CH_LOW_X) || (data_byte == CH_UP_X)) begin
            res.mode_nxt = SM_DIGITS;
          end else if (hex) begin
            take         = 1'b1;
            res.mode_nxt = SM_DIGITS;
          end else begin
            res.mode_nxt = SM_END;
          end
        end
        SM_DIGITS: begin
          if (hex) begin
            take = 1'b1;
          end else begin
            res.mode_nxt = SM_END;
          end
        end
        default: begin
        end
      endcase
    end
    // Shifting in a digit overflows exactly when the top nibble is nonzero.
    res.digit_ovf = take && (|hdr_value[COUNT_BITS-1 -: HEX_DIGIT_BITS]);
  end

  assign ovf = res.digit_ovf;

  always_comb begin
    if (res.line_end) begin
      hdr_value_nxt = '0;
    end else if (ovf) begin
      hdr_value_nxt = '1;
    end else if (take) begin
      hdr_value_nxt = {hdr_value[COUNT_BITS-HEX_DIGIT_BITS-1:0], dval};
    end else begin
      hdr_value_nxt = hdr_value;
    end
  end

endmodule

`default_nettype wire

@@ src/http_chunked_decoder.sv @@
// HTTP chunked transfer decoder, top level.
// Depends on hcd_pkg and hcd_hdr_scan.
//
// Usage: one raw byte of a chunked body enters per transfer on the in_
// channel (valid/ready). Each byte produces exactly one result on the out_
// channel: the byte with out_is_payload set when it belongs to a chunk body
// (out_out_byte is zero otherwise), out_stream_done once a zero-length chunk
// header has ended, and out_length_overflow once any header length saturated
// at 2^COUNT_BITS-1.
// Path: an accepted byte enters the input register; its result is then
// registered in the result register, from which it is offered.
// Throughput: one byte per cycle while the receiver keeps up; a header byte
// costs a hex digit shift and a saturation check, a body byte a decrement of the body counter.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to the start of a header line with no overflow recorded.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, and in_ready drops once both are full. No
// byte is lost or repeated.
`default_nettype none

module http_chunked_decoder
  import hcd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_is_payload,
  output logic       out_stream_done,
  output logic       out_length_overflow
);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_BODY     = 3'd1,
    PH_TRAIL_CR = 3'd2,
    PH_TRAIL_LF = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r,   out_byte_nxt;
  logic                  payload_r,    payload_nxt;
  logic                  done_r;
  logic                  overflow_r,   overflow_nxt;
  phase_t                phase_r,      phase_nxt;
  logic [COUNT_BITS-1:0] body_left_r,  body_left_nxt;
  logic [COUNT_BITS-1:0] hdr_value_r,  hdr_value_nxt;
  scan_mode_t            scan_mode_r,  scan_mode_nxt;

  logic                  can_out;
  logic                  step;
  logic [COUNT_BITS-1:0] scan_value;
  scan_res_t             scan;

  assign can_out  = !out_valid_r || out_ready;
  assign step     = in_valid_r && can_out;
  assign in_ready = !in_valid_r || step;

  hcd_hdr_scan #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .data_byte     (in_byte_r),
    .hdr_value     (hdr_value_r),
    .scan_mode     (scan_mode_r),
    .hdr_value_nxt (scan_value),
    .res           (scan)
  );

  always_comb begin
    phase_nxt     = phase_r;
    body_left_nxt = body_left_r;
    hdr_value_nxt = hdr_value_r;
    scan_mode_nxt = scan_mode_r;
    overflow_nxt  = overflow_r;
    payload_nxt   = 1'b0;
    case (phase_r)
      PH_BODY: begin
        payload_nxt   = 1'b1;
        body_left_nxt = body_left_r - 1'b1;
        if (body_left_r == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
          phase_nxt = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        phase_nxt = PH_TRAIL_LF;
      end
      PH_TRAIL_LF: begin
        phase_nxt     = PH_HEADER;
        hdr_value_nxt = '0;
        scan_mode_nxt = SM_LEAD;
      end
      PH_DONE: begin
      end
      default: begin
        hdr_value_nxt = scan_value;
        scan_mode_nxt = scan.mode_nxt;
        overflow_nxt  = overflow_r || scan.digit_ovf;
        if (scan.line_end) begin
          if (hdr_value_r == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            body_left_nxt = hdr_value_r;
            phase_nxt     = PH_BODY;
          end
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    endcase
    out_byte_nxt = payload_nxt ? in_byte_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      body_left_r <= '0;
      hdr_value_r <= '0;
      scan_mode_r <= SM_LEAD;
      overflow_r  <= 1'b0;
      payload_r   <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (can_out) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        body_left_r <= body_left_nxt;
        hdr_value_r <= hdr_value_nxt;
        scan_mode_r <= scan_mode_nxt;
        overflow_r  <= overflow_nxt;
        payload_r   <= payload_nxt;
        done_r      <= (phase_nxt == PH_DONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
    if (step) begin
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_out_byte        = out_byte_r;
  assign out_is_payload      = payload_r;
  assign out_stream_done     = done_r;
  assign out_length_overflow = overflow_r;

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_left_r != '0)
    else $error("body phase entered with an empty byte count");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("parser left the done phase");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared without reset");

  a_body_payload: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_BODY |=> out_valid_r && payload_r)
    else $error("body byte not marked as payload");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !payload_r |-> out_byte_r == 8'h00)
    else $error("non-payload result carries a nonzero byte");

endmodule

`default_nettype wire
